// ===== sv/ept_pkg.sv =====
package ept_pkg;

  localparam int unsigned CORDIC_STAGES = 24;
  localparam int unsigned MULT_STAGES   = 4;
  // cordic row, sign fix-up stage, product pipeline
  localparam int unsigned PIPE_LAT      = CORDIC_STAGES + 1 + MULT_STAGES;

  localparam int unsigned ANG_W   = 16;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned ROT_W   = 16;
  localparam int unsigned CW      = 34;  // cordic x/y/z datapath width
  localparam int unsigned QW      = 32;  // Q30 sine/cosine width
  localparam int unsigned PW      = 64;  // Q60 product width

  localparam int unsigned NUM_ANG = 3;
  localparam int unsigned NUM_ROT = 9;
  localparam int unsigned IN_W    = 3 * POS_W + NUM_ANG * ANG_W;
  localparam int unsigned OUT_W   = NUM_ROT * ROT_W + 3 * POS_W;

  // angle lane order
  localparam int unsigned ANG_ROLL  = 0;
  localparam int unsigned ANG_PITCH = 1;
  localparam int unsigned ANG_YAW   = 2;

  localparam logic signed [CW-1:0] KINV_Q30 = CW'(652032874);
  localparam logic signed [17:0]   ONE_Q14  = 18'sd16384;

  // arctangent of 2^-i, units of 2^-31 pi
  localparam logic [31:0] ATAN_TAB [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } ept_lane_t;

  typedef struct packed {
    logic signed [QW-1:0] s;
    logic signed [QW-1:0] c;
  } ept_sc_t;

  function automatic logic signed [ROT_W-1:0] sat14(input logic signed [17:0] v);
    logic signed [ROT_W-1:0] r;
    if (v > ONE_Q14) begin
      r = ROT_W'(ONE_Q14);
    end else if (v < -ONE_Q14) begin
      r = ROT_W'(-ONE_Q14);
    end else begin
      r = v[ROT_W-1:0];
    end
    return r;
  endfunction

  // Q60 -> Q14, round half up, saturate to +-1.0
  function automatic logic signed [ROT_W-1:0] rnd46_sat(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = v + (PW'(1) <<< 45);
    return sat14(t[PW-1:46]);
  endfunction

endpackage

// ===== sv/ept_cordic_cell.sv =====
module ept_cordic_cell
  import ept_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic      clk_i,
  input  logic      en_i,
  input  ept_lane_t lane_i [NUM_ANG],
  output ept_lane_t lane_o [NUM_ANG]
);

  localparam logic signed [CW-1:0] ATAN_C = CW'(ATAN_TAB[STAGE]);

  ept_lane_t lane_d [NUM_ANG];
  ept_lane_t lane_q [NUM_ANG];

  always_comb begin
    for (int k = 0; k < NUM_ANG; k++) begin
      lane_d[k].flip = lane_i[k].flip;
      if (!lane_i[k].z[CW-1]) begin
        lane_d[k].x = lane_i[k].x - ($signed(lane_i[k].y) >>> STAGE);
        lane_d[k].y = lane_i[k].y + ($signed(lane_i[k].x) >>> STAGE);
        lane_d[k].z = lane_i[k].z - ATAN_C;
      end else begin
        lane_d[k].x = lane_i[k].x + ($signed(lane_i[k].y) >>> STAGE);
        lane_d[k].y = lane_i[k].y - ($signed(lane_i[k].x) >>> STAGE);
        lane_d[k].z = lane_i[k].z + ATAN_C;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== sv/ept_rot_mult.sv =====
module ept_rot_mult
  import ept_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    en_i,
  input  ept_sc_t                 sc_i  [NUM_ANG],
  output logic signed [ROT_W-1:0] rot_o [NUM_ROT]
);

  logic signed [QW-1:0] sr, cr, sp, cp, sy, cy;

  assign sr = sc_i[ANG_ROLL].s;
  assign cr = sc_i[ANG_ROLL].c;
  assign sp = sc_i[ANG_PITCH].s;
  assign cp = sc_i[ANG_PITCH].c;
  assign sy = sc_i[ANG_YAW].s;
  assign cy = sc_i[ANG_YAW].c;

  // stage 1: pairwise Q60 products
  logic signed [PW-1:0] cycp1_q, sycp1_q, cysp1_q, sysp1_q, cpsr1_q, cpcr1_q;
  logic signed [PW-1:0] sycr1_q, sysr1_q, cycr1_q, cysr1_q;
  logic signed [QW-1:0] sr1_q, cr1_q, sp1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cycp1_q <= PW'(cy) * PW'(cp);
      sycp1_q <= PW'(sy) * PW'(cp);
      cysp1_q <= PW'(cy) * PW'(sp);
      sysp1_q <= PW'(sy) * PW'(sp);
      cpsr1_q <= PW'(cp) * PW'(sr);
      cpcr1_q <= PW'(cp) * PW'(cr);
      sycr1_q <= PW'(sy) * PW'(cr);
      sysr1_q <= PW'(sy) * PW'(sr);
      cycr1_q <= PW'(cy) * PW'(cr);
      cysr1_q <= PW'(cy) * PW'(sr);
      sr1_q   <= sr;
      cr1_q   <= cr;
      sp1_q   <= sp;
    end
  end

  // stage 2: round cy*sp and sy*sp back to Q30, -sp to Q14
  logic signed [PW-1:0] cysp_t, sysp_t;
  logic signed [QW:0]   nsp_t;
  logic signed [QW-1:0] cysp2_q, sysp2_q, sr2_q, cr2_q;
  logic signed [PW-1:0] cycp2_q, sycp2_q, cpsr2_q, cpcr2_q, sycr2_q, sysr2_q, cycr2_q, cysr2_q;
  logic signed [ROT_W-1:0] r20_2_q;

  assign cysp_t = cysp1_q + (PW'(1) <<< 29);
  assign sysp_t = sysp1_q + (PW'(1) <<< 29);
  assign nsp_t  = (QW+1)'(1 <<< 15) - (QW+1)'(sp1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cysp2_q <= cysp_t[61:30];
      sysp2_q <= sysp_t[61:30];
      r20_2_q <= sat14(18'($signed(nsp_t[QW:16])));
      sr2_q   <= sr1_q;
      cr2_q   <= cr1_q;
      cycp2_q <= cycp1_q;
      sycp2_q <= sycp1_q;
      cpsr2_q <= cpsr1_q;
      cpcr2_q <= cpcr1_q;
      sycr2_q <= sycr1_q;
      sysr2_q <= sysr1_q;
      cycr2_q <= cycr1_q;
      cysr2_q <= cysr1_q;
    end
  end

  // stage 3: triple products
  logic signed [PW-1:0] a3_q, b3_q, c3_q, d3_q;
  logic signed [PW-1:0] cycp3_q, sycp3_q, cpsr3_q, cpcr3_q, sycr3_q, sysr3_q, cycr3_q, cysr3_q;
  logic signed [ROT_W-1:0] r20_3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q    <= PW'(cysp2_q) * PW'(sr2_q);
      b3_q    <= PW'(cysp2_q) * PW'(cr2_q);
      c3_q    <= PW'(sysp2_q) * PW'(sr2_q);
      d3_q    <= PW'(sysp2_q) * PW'(cr2_q);
      cycp3_q <= cycp2_q;
      sycp3_q <= sycp2_q;
      cpsr3_q <= cpsr2_q;
      cpcr3_q <= cpcr2_q;
      sycr3_q <= sycr2_q;
      sysr3_q <= sysr2_q;
      cycr3_q <= cycr2_q;
      cysr3_q <= cysr2_q;
      r20_3_q <= r20_2_q;
    end
  end

  // stage 4: sums, round to Q14, saturate
  logic signed [ROT_W-1:0] rot_q [NUM_ROT];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_q[0] <= rnd46_sat(cycp3_q);
      rot_q[1] <= rnd46_sat(a3_q - sycr3_q);
      rot_q[2] <= rnd46_sat(b3_q + sysr3_q);
      rot_q[3] <= rnd46_sat(sycp3_q);
      rot_q[4] <= rnd46_sat(c3_q + cycr3_q);
      rot_q[5] <= rnd46_sat(d3_q - cysr3_q);
      rot_q[6] <= r20_3_q;
      rot_q[7] <= rnd46_sat(cpsr3_q);
      rot_q[8] <= rnd46_sat(cpcr3_q);
    end
  end

  assign rot_o = rot_q;

endmodule

// ===== sv/euler_pose_to_transform.sv =====
// Channel  Dir  Width  Beat contents (lowest bits first)
// s_axis   in   144    pos_x, pos_y, pos_z, roll_angle, pitch_angle, yaw_angle
// m_axis   out  240    rot_00..rot_22 (row major), trans_x, trans_y, trans_z
//
// One beat per cycle in and out while the output is not stalled. An input beat
// passes through 24 CORDIC cells, a sign fix-up stage, four product/sum
// stages and the output register.
// The whole pipeline advances together; a one-beat skid behind the output
// register absorbs a stall, and s_axis_tready drops while the skid is full.
// Reset clears the valid line, the output valid and the skid flag; s_axis_tready
// is low while reset is asserted.
module euler_pose_to_transform
  import ept_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z, roll, pitch, yaw
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // rot_00..rot_22, trans_x, trans_y, trans_z
);

  logic en;
  logic skid_vld_q;

  assign en            = ~skid_vld_q;
  assign s_axis_tready = en & rst_ni;

  // angle prep: fold left half plane by pi, negate at the end
  ept_lane_t lane_in [NUM_ANG];
  ept_lane_t lane_line [CORDIC_STAGES+1][NUM_ANG];

  always_comb begin
    for (int k = 0; k < NUM_ANG; k++) begin
      logic [ANG_W-1:0] ang;
      logic             flp;
      ang = s_axis_tdata[3*POS_W + k*ANG_W +: ANG_W];
      flp = ang[ANG_W-1] ^ ang[ANG_W-2];
      lane_in[k].flip = flp;
      lane_in[k].x    = KINV_Q30;
      lane_in[k].y    = '0;
      lane_in[k].z    = CW'($signed({ang[ANG_W-1] ^ flp, ang[ANG_W-2:0], 16'b0}));
    end
  end

  assign lane_line[0] = lane_in;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ept_cordic_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lane_line[g]),
      .lane_o (lane_line[g+1])
    );
  end

  // sign fix-up stage
  ept_sc_t sc_q [NUM_ANG];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NUM_ANG; k++) begin
        if (lane_line[CORDIC_STAGES][k].flip) begin
          sc_q[k].s <= QW'(-lane_line[CORDIC_STAGES][k].y);
          sc_q[k].c <= QW'(-lane_line[CORDIC_STAGES][k].x);
        end else begin
          sc_q[k].s <= QW'(lane_line[CORDIC_STAGES][k].y);
          sc_q[k].c <= QW'(lane_line[CORDIC_STAGES][k].x);
        end
      end
    end
  end

  logic signed [ROT_W-1:0] rot [NUM_ROT];

  ept_rot_mult u_mult (
    .clk_i (clk_i),
    .en_i  (en),
    .sc_i  (sc_q),
    .rot_o (rot)
  );

  // valid and translation travel alongside the datapath
  logic [PIPE_LAT-1:0] vld_q;
  logic [3*POS_W-1:0]  trans_q [PIPE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      trans_q[0] <= s_axis_tdata[3*POS_W-1:0];
      for (int i = 1; i < PIPE_LAT; i++) begin
        trans_q[i] <= trans_q[i-1];
      end
    end
  end

  logic [OUT_W-1:0] pipe_data;

  always_comb begin
    for (int r = 0; r < NUM_ROT; r++) begin
      pipe_data[r*ROT_W +: ROT_W] = rot[r];
    end
    pipe_data[OUT_W-1 -: 3*POS_W] = trans_q[PIPE_LAT-1];
  end

  // output register with one-beat skid
  logic             arrive;
  logic             out_vld_q;
  logic [OUT_W-1:0] out_q, skid_q;

  assign arrive = en & vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (arrive) begin
        out_vld_q <= 1'b1;
        if (out_vld_q && !m_axis_tready) begin
          skid_vld_q <= 1'b1;
        end
      end else if (skid_vld_q) begin
        if (m_axis_tready) begin
          skid_vld_q <= 1'b0;
        end
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (arrive) begin
      if (!out_vld_q || m_axis_tready) begin
        out_q <= pipe_data;
      end else begin
        skid_q <= pipe_data;
      end
    end else if (skid_vld_q && m_axis_tready) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a beat while output register is empty");

  a_skid_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && !m_axis_tready))
    else $error("skid filled without an output stall");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted beat did not enter the pipeline");

  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[PIPE_LAT-1] && !en) |=> vld_q[PIPE_LAT-1])
    else $error("pipeline beat lost during stall");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench
  import ept_pkg::*;
();

  localparam int unsigned TEST_ITEMS  = 1000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RPT_MAX     = 10;
  localparam int unsigned WANT_DEPTH  = TEST_ITEMS + 64;
  localparam longint      KINV        = 64'sd652032874;

  // arctan(2^-i) in units of 2^-31 pi
  localparam longint ATAN [CORDIC_STAGES] = '{
    'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4,
    'h028B0D43, 'h0145D7E1, 'h00A2F61E, 'h00517C55,
    'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
    'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D,
    'h000028BE, 'h0000145F, 'h00000A30, 'h00000518,
    'h0000028C, 'h00000146, 'h000000A3, 'h00000051
  };

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic [ANG_W-1:0] roll;
    logic [ANG_W-1:0] pitch;
    logic [ANG_W-1:0] yaw;
  } pose_t;

  // typed rows carry the translation expected back
  typedef struct packed {
    pose_t            p;
    logic             typed;
    logic [POS_W-1:0] tx;
    logic [POS_W-1:0] ty;
    logic [POS_W-1:0] tz;
  } pose_row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;  // pos_x, pos_y, pos_z, roll, pitch, yaw
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;        // rot_00..rot_22, trans_x, trans_y, trans_z

  logic             steady   = 1'b0;
  logic             hold_req = 1'b0;
  int unsigned      mismatch_cnt = 0;
  int unsigned      idle_cycles  = 0;
  // expected beats in send order
  logic [OUT_W-1:0] want_mem [WANT_DEPTH];
  int unsigned      want_wr = 0;
  int unsigned      want_rd = 0;

  pose_row_t directed_rows [20] = '{
    '{'{32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h0000}, 1'b1, 32'h0, 32'h0, 32'h0},
    '{'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h0000, 16'h0000, 16'h0000},
      1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
    '{'{32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000},
      1'b1, 32'h80000000, 32'h80000000, 32'h80000000},
    '{'{32'hFFFFFFFF, 32'h00000001, 32'h00010000, 16'h4000, 16'h0000, 16'h0000},
      1'b1, 32'hFFFFFFFF, 32'h00000001, 32'h00010000},
    '{'{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 16'h5555, 16'hAAAA, 16'h1234},
      1'b1, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F},
    '{'{32'hAAAAAAAA, 32'h55555555, 32'h0, 16'h0000, 16'h3FFF, 16'hC001},
      1'b1, 32'hAAAAAAAA, 32'h55555555, 32'h0},
    '{'{32'h0, 32'h0, 32'h0, 16'h0000, 16'h4000, 16'h0000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h4000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'hC000, 16'hC000, 16'hC000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 1'b0, '0, '0, '0},
    // quadrant edges, where the half-turn flip switches
    '{'{32'h0, 32'h0, 32'h0, 16'h3FFF, 16'h4001, 16'hBFFF}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'hC001, 16'h8001, 16'h7FFF}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h2000, 16'h2000, 16'h2000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'hE000, 16'h6000, 16'hA000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h0001, 16'hFFFF, 16'h0001}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h8000, 16'h0000, 16'h0000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h0000, 16'h8000, 16'h0000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h0000, 16'h0000, 16'h8000}, 1'b0, '0, '0, '0},
    // gimbal lock
    '{'{32'h0, 32'h0, 32'h0, 16'h4000, 16'h4000, 16'h4000}, 1'b0, '0, '0, '0},
    '{'{32'h0, 32'h0, 32'h0, 16'h0000, 16'hC000, 16'h0000}, 1'b0, '0, '0, '0}
  };

  euler_pose_to_transform i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // sine and cosine in Q30; left half plane turned by pi, negated after
  function automatic void cordic_sincos(input logic [ANG_W-1:0] ang,
                                        output longint s, output longint c);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    int          i;
    a    = {ang, 16'h0000};
    flip = a[31] ^ a[30];
    if (flip) a[31] = ~a[31];
    z = longint'($signed(a));
    x = KINV;
    y = 0;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  // round half up, then drop sh fraction bits
  function automatic longint round_shift(input longint v, input int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic logic [ROT_W-1:0] q14_clamp(input longint v);
    if (v > 16384) return 16'sd16384;
    if (v < -16384) return -16'sd16384;
    return v[ROT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] rpy_transform(input pose_t p);
    longint sr, cr, sp, cp, sy, cy, cysp, sysp;
    logic [NUM_ROT*ROT_W-1:0] rot;
    cordic_sincos(p.roll, sr, cr);
    cordic_sincos(p.pitch, sp, cp);
    cordic_sincos(p.yaw, sy, cy);
    cysp = round_shift(cy * sp, 30);
    sysp = round_shift(sy * sp, 30);
    rot[0*ROT_W +: ROT_W] = q14_clamp(round_shift(cy * cp, 46));
    rot[1*ROT_W +: ROT_W] = q14_clamp(round_shift(cysp * sr - sy * cr, 46));
    rot[2*ROT_W +: ROT_W] = q14_clamp(round_shift(cysp * cr + sy * sr, 46));
    rot[3*ROT_W +: ROT_W] = q14_clamp(round_shift(sy * cp, 46));
    rot[4*ROT_W +: ROT_W] = q14_clamp(round_shift(sysp * sr + cy * cr, 46));
    rot[5*ROT_W +: ROT_W] = q14_clamp(round_shift(sysp * cr - cy * sr, 46));
    rot[6*ROT_W +: ROT_W] = q14_clamp(round_shift(-sp, 16));
    rot[7*ROT_W +: ROT_W] = q14_clamp(round_shift(cp * sr, 46));
    rot[8*ROT_W +: ROT_W] = q14_clamp(round_shift(cp * cr, 46));
    return {p.z, p.y, p.x, rot};
  endfunction

  function automatic logic [ANG_W-1:0] rand_angle();
    logic [ANG_W-1:0] a;
    case ($urandom_range(9))
      0, 1:    a = {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(8)) - 16'd4;
      2:       a = ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
      3:       a = 16'($urandom_range(16)) - 16'd8;
      default: a = 16'($urandom);
    endcase
    return a;
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    case ($urandom_range(15))
      0:       return 32'h7FFFFFFF;
      1:       return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= RPT_MAX) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_transform(input logic [OUT_W-1:0] want,
                                          input logic [OUT_W-1:0] got);
    string            axes = "xyz";
    logic [POS_W-1:0] e, a;
    int unsigned      off;
    int               f;
    string            name;
    for (f = 0; f < NUM_ROT + 3; f++) begin
      if (f < NUM_ROT) begin
        off  = f * ROT_W;
        e    = 32'(want[off +: ROT_W]);
        a    = 32'(got[off +: ROT_W]);
        name = $sformatf("rot_%0d%0d", f / 3, f % 3);
      end else begin
        off  = NUM_ROT * ROT_W + (f - NUM_ROT) * POS_W;
        e    = want[off +: POS_W];
        a    = got[off +: POS_W];
        name = $sformatf("trans_%c", axes[f - NUM_ROT]);
      end
      if (a !== e) note_failure($sformatf("%s expected %h got %h", name, e, a));
    end
  endfunction

  task automatic send_pose(input pose_t p, input logic [OUT_W-1:0] want);
    if (!steady && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.yaw, p.pitch, p.roll, p.z, p.y, p.x};
    do @(posedge clk_i); while (!s_axis_tready);
    want_mem[want_wr] = want;
    want_wr++;
  endtask

  initial begin : stimulus
    pose_t            p;
    logic [OUT_W-1:0] want;
    int               k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (k = 0; k < $size(directed_rows); k++) begin
      want = rpy_transform(directed_rows[k].p);
      if (directed_rows[k].typed) begin
        want[OUT_W-1 -: 3*POS_W] = {directed_rows[k].tz, directed_rows[k].ty,
                                    directed_rows[k].tx};
      end
      send_pose(directed_rows[k].p, want);
    end
    for (k = 0; k < TEST_ITEMS; k++) begin
      steady = (k >= 300 && k < 550);
      // sink holds off while poses keep coming: pipeline fills, tready drops
      if (k == 700) hold_req = 1'b1;
      p = '{rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(), rand_angle()};
      send_pose(p, rpy_transform(p));
    end
    s_axis_tvalid <= 1'b0;
    while (want_rd != want_wr) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : sink_ready
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (want_rd == want_wr) begin
        note_failure($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        check_transform(want_mem[want_rd], m_axis_tdata);
        want_rd++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
